// File: sv/sipq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insertion priority queue package
// Sizes, request codes, entry type and the control bundle shared by the cells.
// ----------------------------------------------------------------------------
package sipq_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PRIO_W = 16;
	localparam int TAG_W  = 32;
	localparam int REQ_W  = 2;
	localparam int OCC_W  = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_PEEK = 2'd2
	} req_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   new_entry;
	} cell_ctrl_t;

endpackage

// File: sv/sipq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one queue request per transfer.
// ----------------------------------------------------------------------------
interface sipq_req_if;
	import sipq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [PRIO_W-1:0] in_priority;
	logic [TAG_W-1:0]         in_tag;

	modport source (output valid, req_type, in_priority, in_tag, input ready);
	modport sink   (input valid, req_type, in_priority, in_tag, output ready);

endinterface

// File: sv/sipq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one queue response per transfer.
// ----------------------------------------------------------------------------
interface sipq_rsp_if;
	import sipq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     success;
	logic signed [PRIO_W-1:0] out_priority;
	logic [TAG_W-1:0]         out_tag;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, success, out_priority, out_tag, occupancy, input ready);
	modport sink   (input valid, success, out_priority, out_tag, occupancy, output ready);

endinterface

// File: sv/sipq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry; keeps it, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sipq_cell (
	input  logic                clk,
	input  sipq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                left_ge,
	input  sipq_pkg::entry_t    left_entry,
	input  sipq_pkg::entry_t    right_entry,
	output sipq_pkg::entry_t    entry,
	output logic                ge
);
	import sipq_pkg::*;

	entry_t entry_q;

	// The new entry goes behind every held entry whose priority is not larger.
	assign ge    = occupied && ($signed(ctrl.new_entry.prio) >= $signed(entry_q.prio));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (ge) begin
					entry_q <= entry_q;
				end else if (left_ge) begin
					entry_q <= ctrl.new_entry;
				end else begin
					entry_q <= left_entry;
				end
			end
			CELL_SHIFT: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

// File: sv/sorted_insertion_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-insertion priority queue
// Shift-register priority queue built from a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries (priority and tag) in ascending priority
// order, cell 0 being the front; equal priorities leave in arrival order. Each
// request is handled at once: every cell compares its priority with the
// incoming one at the same time and then keeps its entry, loads the new entry
// or takes its neighbor's, so one request is accepted per cycle unless the
// output stalls; its response appears in the output register on the following
// cycle. A new request is taken while the previous response is still waiting,
// as long as that response is being transferred in the same cycle. An enqueue
// into a full queue, and a dequeue or peek of an empty queue, leave the queue
// unchanged and report success low with zero priority and tag.
module sorted_insertion_priority_queue_top (
	input logic   clk,
	input logic   arst_n,
	sipq_req_if.sink   req,
	sipq_rsp_if.source rsp
);
	import sipq_pkg::*;

	// Entry count and output register state.
	logic [CNT_W-1:0]         count_q;
	logic                     rsp_valid_q;
	logic                     success_q;
	logic signed [PRIO_W-1:0] out_priority_q;
	logic [TAG_W-1:0]         out_tag_q;
	logic [OCC_W-1:0]         occupancy_q;

	// Cell row wiring.
	entry_t           cell_entry [DEPTH];
	logic [DEPTH-1:0] cell_ge;
	logic [DEPTH-1:0] cell_occ;
	cell_ctrl_t       ctrl;

	// Request decode.
	logic             accept;
	logic             is_full;
	logic             is_empty;
	logic             enq_ok;
	logic             front_ok;
	logic             deq_ok;
	logic [CNT_W-1:0] count_next;

	// A request transfers when the output register is free or being emptied.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	assign enq_ok   = (req.req_type == REQ_ENQ) && !is_full;
	assign front_ok = ((req.req_type == REQ_DEQ) || (req.req_type == REQ_PEEK)) && !is_empty;
	assign deq_ok   = (req.req_type == REQ_DEQ) && !is_empty;

	always_comb begin
		count_next = count_q;
		if (accept && enq_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (accept && deq_ok) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// Broadcast the operation and the new entry to every cell.
	always_comb begin
		ctrl.new_entry.prio = req.in_priority;
		ctrl.new_entry.tag  = req.in_tag;
		if (accept && enq_ok) begin
			ctrl.op = CELL_INSERT;
		end else if (accept && deq_ok) begin
			ctrl.op = CELL_SHIFT;
		end else begin
			ctrl.op = CELL_HOLD;
		end
	end

	// The row of cells. The front cell sees an imaginary smaller neighbor on
	// its left, so it loads the new entry whenever its own priority is larger.
	// The back cell refills from itself on a dequeue; that slot becomes empty.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_front
			sipq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (cell_occ[i]),
				.left_ge     (1'b1),
				.left_entry  (ctrl.new_entry),
				.right_entry (cell_entry[i+1]),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end else if (i == DEPTH - 1) begin : g_back
			sipq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (cell_occ[i]),
				.left_ge     (cell_ge[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i]),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end else begin : g_mid
			sipq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occupied    (cell_occ[i]),
				.left_ge     (cell_ge[i-1]),
				.left_entry  (cell_entry[i-1]),
				.right_entry (cell_entry[i+1]),
				.entry       (cell_entry[i]),
				.ge          (cell_ge[i])
			);
		end
	end

	// Control state: entry count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload, loaded from the front cell before it is updated.
	always_ff @(posedge clk) begin
		if (accept) begin
			success_q   <= enq_ok || front_ok;
			occupancy_q <= OCC_W'(count_next);
			if (front_ok) begin
				out_priority_q <= cell_entry[0].prio;
				out_tag_q      <= cell_entry[0].tag;
			end else begin
				out_priority_q <= '0;
				out_tag_q      <= '0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.success      = success_q;
	assign rsp.out_priority = out_priority_q;
	assign rsp.out_tag      = out_tag_q;
	assign rsp.occupancy    = occupancy_q;

`ifndef SYNTH
	// The count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds queue depth");

	// A transferred dequeue of a non-empty queue removes exactly one entry.
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == REQ_DEQ) && !is_empty)
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("dequeue did not remove one entry");

	// The two front entries stay in priority order.
	a_front_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> ($signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio)))
		else $error("front entries out of priority order");

	// Every transferred request yields a pending response on the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("response missing after request transfer");
`endif

endmodule
